[sv/cdi_pkg.sv]
// Shared types, codes and constants for the cosmic distance integrator.
`default_nettype none
package cdi_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FDEN,
        ST_FDIV,
        ST_ZDIV,
        ST_SQ,
        ST_CUBE,
        ST_OMM,
        ST_SQRT,
        ST_LBM,
        ST_RCP,
        ST_AVG,
        ST_IMUL,
        ST_ADJM,
        ST_ADJD,
        ST_FIN,
        ST_DONE
    } cdi_state_t;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } cdi_op_t;

    // Commands carried by an input request
    localparam logic [1:0] CMD_COMOVING   = 2'd0;
    localparam logic [1:0] CMD_LUMINOSITY = 2'd1;
    localparam logic [1:0] CMD_ANGULAR    = 2'd2;
    localparam logic [1:0] CMD_LOOKBACK   = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_HUBBLE = 2'd0;
    localparam logic [1:0] REG_OMEGA  = 2'd1;
    localparam logic [1:0] REG_STEPS  = 2'd2;

    localparam logic [15:0] HUBBLE_RST = 16'd17254;
    localparam logic [16:0] OMEGA_RST  = 17'd20644;
    localparam logic [12:0] STEPS_RST  = 13'd1000;

    localparam logic [12:0] MAX_STEPS      = 13'd4096;
    localparam logic [12:0] LOOKBACK_STEPS = 13'd1000;

    // Scale constants: c in m/s << 24, and 2.56e8 << 16
    localparam logic [63:0] C_NUM      = {10'd0, 30'd299792458, 24'd0};
    localparam logic [63:0] T_NUM      = {20'd0, 28'd256000000, 16'd0};
    localparam logic [63:0] C_DEN_MUL  = 64'd1000;
    localparam logic [63:0] T_DEN_MUL  = 64'd1022;
    localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ONE_Q48    = 64'h0001_0000_0000_0000;
    localparam logic [39:0] OUT_MAX    = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic        start;
        cdi_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } cdi_req_t;

    typedef struct packed {
        logic         done;
        logic         busy;
        logic [127:0] data;
    } cdi_rsp_t;

endpackage
`default_nettype wire

[sv/cdi_arith.sv]
// Shared bit-serial multiply, divide and square-root unit on one adder.
`default_nettype none
module cdi_arith (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire cdi_pkg::cdi_req_t req,
    output cdi_pkg::cdi_rsp_t rsp
);

    cdi_pkg::cdi_op_t op_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [127:0] acc_reg;
    logic [63:0]  opb_reg;

    logic [65:0]  add_x;
    logic [65:0]  add_y;
    logic         sub;
    logic [65:0]  sum;
    logic         ge;

    // Select adder operands for the running operation
    always_comb begin
        add_x = '0;
        add_y = '0;
        sub   = 1'b0;
        unique case (op_reg)
            cdi_pkg::OP_MUL: begin
                add_x = {2'b00, acc_reg[127:64]};
                add_y = acc_reg[0] ? {2'b00, opb_reg} : '0;
            end
            cdi_pkg::OP_DIV: begin
                add_x = {1'b0, acc_reg[127:63]};
                add_y = {2'b00, opb_reg};
                sub   = 1'b1;
            end
            cdi_pkg::OP_SQRT: begin
                add_x = acc_reg[127:62];
                add_y = {opb_reg, 2'b01};
                sub   = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
        sum = add_x + (sub ? ~add_y : add_y) + {65'd0, sub};
        ge  = ~sum[65];
    end

    // Control: load on start, count down steps, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= cdi_pkg::OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == cdi_pkg::OP_SQRT) ? 7'd32 : 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one shift-add or shift-subtract step a cycle while busy
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= {64'd0, req.a};
            opb_reg <= (req.op == cdi_pkg::OP_SQRT) ? 64'd0 : req.b;
        end else if (busy_reg) begin
            unique case (op_reg)
                cdi_pkg::OP_MUL: begin
                    acc_reg <= {sum[64:0], acc_reg[63:1]};
                end
                cdi_pkg::OP_DIV: begin
                    acc_reg <= {(ge ? sum[63:0] : add_x[63:0]), acc_reg[62:0], ge};
                end
                cdi_pkg::OP_SQRT: begin
                    acc_reg <= {(ge ? sum[63:0] : add_x[63:0]), acc_reg[61:0], 2'b00};
                    opb_reg <= {opb_reg[62:0], ge};
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.data = (op_reg == cdi_pkg::OP_SQRT) ? {64'd0, opb_reg} : acc_reg;

endmodule
`default_nettype wire

[sv/cosmic_distance_integrator_top.sv]
// Top level: sequencer for the trapezoidal flat Lambda-CDM distance integrator.
//
//  channel   dir   handshake              payload
//  s_        in    s_tvalid / s_tready    s_tdata redshift, s_tuser command
//  m_        out   m_tvalid / m_tready    m_tdata result_value, m_tuser saturated
//  cfg_      in    cfg_we                 cfg_addr index, cfg_wdata value
//
// The time of one request grows with the step count n; luminosity and angular distance
// add one more unit operation, and lookback always integrates over 1000 steps.
// The bit-serial shared unit sets it, as it runs one multiply, divide or root at a time.
// A zero redshift or zero H0 skips the unit and goes straight to the done state.
// aresetn is synchronous; it clears the sequencer and restores register defaults.
// s_tready is high only while idle; a finished result waits in the output register.
`default_nettype none
module cosmic_distance_integrator_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [25:0] redshift
    input  wire  [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [39:0] result_value
    output logic        m_tuser,   // [0] saturated
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [16:0] cfg_wdata
);

    cdi_pkg::cdi_state_t state_reg, state_next;
    cdi_pkg::cdi_req_t   arith_req;
    cdi_pkg::cdi_rsp_t   arith_rsp;

    logic [15:0]  hubble_reg;
    logic [16:0]  omega_reg;
    logic [12:0]  steps_reg;

    logic         pend_reg;
    logic         m_valid_reg;
    logic [39:0]  m_data_reg;
    logic         m_sat_reg;

    logic [1:0]   cmd_reg;
    logic [25:0]  z_reg;
    logic [12:0]  n_reg;
    logic [63:0]  fact_reg;
    logic [25:0]  zq_reg;
    logic [12:0]  zr_reg;
    logic [12:0]  zrem_reg;
    logic [25:0]  zi_reg;
    logic [12:0]  i_reg;
    logic [26:0]  a_reg;
    logic [63:0]  tmp_reg;
    logic [63:0]  sum_reg;
    logic [63:0]  integ_reg;
    logic         ovf_reg;
    logic [39:0]  res_reg;
    logic         sat_reg;

    logic         accept;
    logic         is_arith;
    logic         out_free;
    logic [12:0]  steps_clamped;
    logic [13:0]  rr;
    logic [26:0]  one_plus_z;
    logic [63:0]  r_val;
    logic [63:0]  fin_val;
    logic         fin_ovf;

    cdi_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .rsp     (arith_rsp)
    );

    assign s_tready = (state_reg == cdi_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_arith = (state_reg != cdi_pkg::ST_IDLE) && (state_reg != cdi_pkg::ST_DONE);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

    assign steps_clamped = (steps_reg == 13'd0) ? 13'd1 :
                           (steps_reg > cdi_pkg::MAX_STEPS) ? cdi_pkg::MAX_STEPS : steps_reg;
    assign rr           = {1'b0, zrem_reg} + {1'b0, zr_reg};
    assign one_plus_z   = 27'd65536 + {1'b0, z_reg};
    assign r_val        = arith_rsp.data[63:0];
    assign fin_ovf      = ovf_reg || (arith_rsp.data[127:96] != 32'd0);
    assign fin_val      = arith_rsp.data[95:32];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdi_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[25:0] == 26'd0 || hubble_reg == 16'd0) begin
                        state_next = cdi_pkg::ST_DONE;
                    end else begin
                        state_next = cdi_pkg::ST_FDEN;
                    end
                end
            end
            cdi_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = cdi_pkg::ST_IDLE;
                end
            end
            default: begin
                if (arith_rsp.done && pend_reg) begin
                    unique case (state_reg)
                        cdi_pkg::ST_FDEN: state_next = cdi_pkg::ST_FDIV;
                        cdi_pkg::ST_FDIV: state_next = cdi_pkg::ST_ZDIV;
                        cdi_pkg::ST_ZDIV: state_next = cdi_pkg::ST_SQ;
                        cdi_pkg::ST_SQ:   state_next = cdi_pkg::ST_CUBE;
                        cdi_pkg::ST_CUBE: state_next = cdi_pkg::ST_OMM;
                        cdi_pkg::ST_OMM:  state_next = cdi_pkg::ST_SQRT;
                        cdi_pkg::ST_SQRT: state_next = (cmd_reg == cdi_pkg::CMD_LOOKBACK) ?
                                                       cdi_pkg::ST_LBM : cdi_pkg::ST_RCP;
                        cdi_pkg::ST_LBM:  state_next = cdi_pkg::ST_RCP;
                        cdi_pkg::ST_RCP:  state_next = (i_reg == n_reg) ?
                                                       cdi_pkg::ST_AVG : cdi_pkg::ST_SQ;
                        cdi_pkg::ST_AVG:  state_next = cdi_pkg::ST_IMUL;
                        cdi_pkg::ST_IMUL: begin
                            if (cmd_reg == cdi_pkg::CMD_LUMINOSITY) begin
                                state_next = cdi_pkg::ST_ADJM;
                            end else if (cmd_reg == cdi_pkg::CMD_ANGULAR) begin
                                state_next = cdi_pkg::ST_ADJD;
                            end else begin
                                state_next = cdi_pkg::ST_FIN;
                            end
                        end
                        cdi_pkg::ST_ADJM: state_next = cdi_pkg::ST_FIN;
                        cdi_pkg::ST_ADJD: state_next = cdi_pkg::ST_FIN;
                        cdi_pkg::ST_FIN:  state_next = cdi_pkg::ST_DONE;
                        default:          state_next = cdi_pkg::ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Arithmetic request for the current state
    always_comb begin
        arith_req.start = is_arith && !pend_reg;
        arith_req.op    = cdi_pkg::OP_MUL;
        arith_req.a     = '0;
        arith_req.b     = '0;
        unique case (state_reg)
            cdi_pkg::ST_FDEN: begin
                arith_req.a = {48'd0, hubble_reg};
                arith_req.b = (cmd_reg == cdi_pkg::CMD_LOOKBACK) ?
                              cdi_pkg::T_DEN_MUL : cdi_pkg::C_DEN_MUL;
            end
            cdi_pkg::ST_FDIV: begin
                arith_req.op = cdi_pkg::OP_DIV;
                arith_req.a  = (cmd_reg == cdi_pkg::CMD_LOOKBACK) ?
                               cdi_pkg::T_NUM : cdi_pkg::C_NUM;
                arith_req.b  = tmp_reg;
            end
            cdi_pkg::ST_ZDIV: begin
                arith_req.op = cdi_pkg::OP_DIV;
                arith_req.a  = {38'd0, z_reg};
                arith_req.b  = {51'd0, n_reg};
            end
            cdi_pkg::ST_SQ: begin
                arith_req.a = {37'd0, 27'd65536 + {1'b0, zi_reg}};
                arith_req.b = {37'd0, 27'd65536 + {1'b0, zi_reg}};
            end
            cdi_pkg::ST_CUBE: begin
                arith_req.a = tmp_reg;
                arith_req.b = {37'd0, a_reg};
            end
            cdi_pkg::ST_OMM: begin
                arith_req.a = tmp_reg;
                arith_req.b = {47'd0, omega_reg};
            end
            cdi_pkg::ST_SQRT: begin
                arith_req.op = cdi_pkg::OP_SQRT;
                arith_req.a  = tmp_reg;
            end
            cdi_pkg::ST_LBM: begin
                arith_req.a = tmp_reg;
                arith_req.b = {37'd0, a_reg};
            end
            cdi_pkg::ST_RCP: begin
                arith_req.op = cdi_pkg::OP_DIV;
                arith_req.a  = cdi_pkg::ONE_Q48;
                arith_req.b  = tmp_reg;
            end
            cdi_pkg::ST_AVG: begin
                arith_req.op = cdi_pkg::OP_DIV;
                arith_req.a  = sum_reg;
                arith_req.b  = {50'd0, n_reg, 1'b0};
            end
            cdi_pkg::ST_IMUL: begin
                arith_req.a = tmp_reg;
                arith_req.b = {38'd0, z_reg};
            end
            cdi_pkg::ST_ADJM: begin
                arith_req.a = integ_reg;
                arith_req.b = {37'd0, one_plus_z};
            end
            cdi_pkg::ST_ADJD: begin
                arith_req.op = cdi_pkg::OP_DIV;
                arith_req.a  = {integ_reg[47:0], 16'd0};
                arith_req.b  = {37'd0, one_plus_z};
            end
            cdi_pkg::ST_FIN: begin
                arith_req.a = integ_reg;
                arith_req.b = fact_reg;
            end
            default: begin
                arith_req.start = 1'b0;
            end
        endcase
    end

    // Control registers, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdi_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            hubble_reg  <= cdi_pkg::HUBBLE_RST;
            omega_reg   <= cdi_pkg::OMEGA_RST;
            steps_reg   <= cdi_pkg::STEPS_RST;
        end else begin
            state_reg <= state_next;
            if (arith_req.start) begin
                pend_reg <= 1'b1;
            end else if (arith_rsp.done) begin
                pend_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    cdi_pkg::REG_HUBBLE: hubble_reg <= cfg_wdata[15:0];
                    cdi_pkg::REG_OMEGA:  omega_reg  <= cfg_wdata;
                    cdi_pkg::REG_STEPS:  steps_reg  <= cfg_wdata[12:0];
                    default:             hubble_reg <= hubble_reg;
                endcase
            end
            if (state_reg == cdi_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers: capture each unit result
    always_ff @(posedge aclk) begin
        if (state_reg == cdi_pkg::ST_DONE && out_free) begin
            m_data_reg <= res_reg;
            m_sat_reg  <= sat_reg;
        end
        if (accept) begin
            cmd_reg <= s_tuser;
            z_reg   <= s_tdata[25:0];
            n_reg   <= (s_tuser == cdi_pkg::CMD_LOOKBACK) ? cdi_pkg::LOOKBACK_STEPS
                                                          : steps_clamped;
            ovf_reg <= 1'b0;
            res_reg <= (s_tdata[25:0] == 26'd0) ? 40'd0 : cdi_pkg::OUT_MAX;
            sat_reg <= (s_tdata[25:0] != 26'd0);
        end
        if (arith_rsp.done && pend_reg) begin
            unique case (state_reg)
                cdi_pkg::ST_FDEN: tmp_reg  <= arith_rsp.data[63:0];
                cdi_pkg::ST_FDIV: fact_reg <= arith_rsp.data[63:0];
                cdi_pkg::ST_ZDIV: begin
                    zq_reg   <= arith_rsp.data[25:0];
                    zr_reg   <= arith_rsp.data[76:64];
                    zrem_reg <= '0;
                    zi_reg   <= '0;
                    i_reg    <= '0;
                    sum_reg  <= '0;
                end
                cdi_pkg::ST_SQ:   tmp_reg <= arith_rsp.data[63:0];
                cdi_pkg::ST_CUBE: tmp_reg <= arith_rsp.data[79:16] - cdi_pkg::ONE_Q32;
                cdi_pkg::ST_OMM:  tmp_reg <= arith_rsp.data[79:16] + cdi_pkg::ONE_Q32;
                cdi_pkg::ST_SQRT: tmp_reg <= arith_rsp.data[63:0];
                cdi_pkg::ST_LBM:  tmp_reg <= arith_rsp.data[79:16];
                cdi_pkg::ST_RCP: begin
                    // weight end samples once, interior samples twice
                    if (i_reg == 13'd0 || i_reg == n_reg) begin
                        sum_reg <= sum_reg + r_val;
                    end else begin
                        sum_reg <= sum_reg + {r_val[62:0], 1'b0};
                    end
                    // advance sample: zi = floor(i*z/n) kept as quotient and remainder
                    i_reg <= i_reg + 13'd1;
                    if (rr >= {1'b0, n_reg}) begin
                        zrem_reg <= 13'(rr - {1'b0, n_reg});
                        zi_reg   <= zi_reg + zq_reg + 26'd1;
                    end else begin
                        zrem_reg <= rr[12:0];
                        zi_reg   <= zi_reg + zq_reg;
                    end
                end
                cdi_pkg::ST_AVG:  tmp_reg <= arith_rsp.data[63:0];
                cdi_pkg::ST_IMUL: begin
                    integ_reg <= (arith_rsp.data[127:80] != 48'd0) ? '1 : arith_rsp.data[79:16];
                end
                cdi_pkg::ST_ADJM: begin
                    if (arith_rsp.data[127:80] != 48'd0) begin
                        ovf_reg   <= 1'b1;
                        integ_reg <= '1;
                    end else begin
                        integ_reg <= arith_rsp.data[79:16];
                    end
                end
                cdi_pkg::ST_ADJD: integ_reg <= arith_rsp.data[63:0];
                cdi_pkg::ST_FIN: begin
                    if (fin_ovf || fin_val[63:40] != 24'd0) begin
                        res_reg <= cdi_pkg::OUT_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        res_reg <= fin_val[39:0];
                        sat_reg <= 1'b0;
                    end
                end
                default: tmp_reg <= tmp_reg;
            endcase
        end
        // hold 1+zi for the cube and lookback steps
        if (state_reg == cdi_pkg::ST_SQ && arith_req.start) begin
            a_reg <= 27'd65536 + {1'b0, zi_reg};
        end
    end

    // No unit work while a new request can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !arith_rsp.busy)
        else $error("arith unit busy while idle");

    // A saturated result carries the all-ones value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == cdi_pkg::OUT_MAX))
        else $error("saturated result not clamped");

    // Zero redshift goes straight to the result stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[25:0] == 26'd0) |=> state_reg == cdi_pkg::ST_DONE)
        else $error("zero redshift not short-cut");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the cosmic distance integrator top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    typedef struct {
        logic [1:0]  command;
        logic [25:0] redshift;
    } distance_req_t;

    typedef struct {
        logic [39:0] value;
        logic        sat;
    } distance_rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [16:0] cfg_wdata;

    // Shadow copies of the configuration and of the integrator working state
    logic [15:0] h0_reg;
    logic [16:0] omega_reg;
    logic [12:0] steps_reg;
    logic [63:0] sum_shadow;
    logic [12:0] idx_shadow;
    logic [63:0] zi_shadow;

    distance_req_t pending_reqs[$];
    distance_rsp_t expected_rsps[$];
    int            send_gap;
    int            recv_stall;
    bit            no_idle;
    int            error_count;

    cosmic_distance_integrator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // floor(a*b / 2^sh); flag overflow past 64 bits
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int sh, inout bit ovf);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> sh;
        if (prod[127:64] != 64'd0) begin
            ovf = 1'b1;
            return {64{1'b1}};
        end
        return prod[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 1/E(z) or 1/((1+z)E(z)) in Q.32 at sample zi (Q.16)
    function automatic logic [63:0] inv_expansion(input logic [63:0] zi, input bit lookback);
        logic [63:0] a, a2, cube, c, m, e, d, om;
        om   = {47'd0, omega_reg};
        a    = 64'd65536 + zi;
        a2   = a * a;
        cube = (a2 >> 16) * a + (((a2 & 64'hFFFF) * a) >> 16);
        c    = cube - cdi_pkg::ONE_Q32;
        m    = (c >> 16) * om + (((c & 64'hFFFF) * om) >> 16);
        e    = root_floor(cdi_pkg::ONE_Q32 + m);
        d    = lookback ? ((e * a) >> 16) : e;
        return cdi_pkg::ONE_Q48 / d;
    endfunction

    function automatic logic [63:0] trapezoid_integral(input logic [63:0] z, input logic [63:0] n,
                                                       input bit lookback);
        logic [63:0] s, zi, r, avg;
        bit          dummy;
        s     = 64'd0;
        zi    = 64'd0;
        dummy = 1'b0;
        for (logic [63:0] i = 0; i <= n; i++) begin
            zi = (i * z) / n;
            r  = inv_expansion(zi, lookback);
            s  = s + ((i == 0 || i == n) ? r : (r << 1));
        end
        sum_shadow = s;
        idx_shadow = n[12:0];
        zi_shadow  = zi;
        avg = s / (n << 1);
        return mul_shift(avg, z, 16, dummy);
    endfunction

    function automatic distance_rsp_t predict_distance(input distance_req_t rq);
        distance_rsp_t rs;
        logic [63:0]   z, h, n, integ, factor, val;
        bit            ovf;
        ovf = 1'b0;
        z   = {38'd0, rq.redshift};
        h   = {48'd0, h0_reg};
        n   = {51'd0, steps_reg};
        if (z == 0) begin
            rs.value = 40'd0;
            rs.sat   = 1'b0;
            return rs;
        end
        if (h == 0) begin
            rs.value = cdi_pkg::OUT_MAX;
            rs.sat   = 1'b1;
            return rs;
        end
        if (n == 0) n = 1;
        if (n > 64'd4096) n = 64'd4096;
        if (rq.command == cdi_pkg::CMD_LOOKBACK) begin
            integ  = trapezoid_integral(z, 64'd1000, 1'b1);
            factor = cdi_pkg::T_NUM / (cdi_pkg::T_DEN_MUL * h);
        end else begin
            integ = trapezoid_integral(z, n, 1'b0);
            if (rq.command == cdi_pkg::CMD_LUMINOSITY)
                integ = mul_shift(integ, 64'd65536 + z, 16, ovf);
            else if (rq.command == cdi_pkg::CMD_ANGULAR)
                integ = (integ << 16) / (64'd65536 + z);
            factor = cdi_pkg::C_NUM / (cdi_pkg::C_DEN_MUL * h);
        end
        val = mul_shift(integ, factor, 32, ovf);
        if (ovf || val > {24'd0, cdi_pkg::OUT_MAX}) begin
            rs.value = cdi_pkg::OUT_MAX;
            rs.sat   = 1'b1;
        end else begin
            rs.value = val[39:0];
            rs.sat   = 1'b0;
        end
        return rs;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request driver: hold until accepted, then advance to the next pending request
    always @(posedge aclk) begin
        distance_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                rq.command  = s_tuser;
                rq.redshift = s_tdata[25:0];
                expected_rsps.push_back(predict_distance(rq));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    rq = pending_reqs.pop_front();
                    s_tdata  <= {6'd0, rq.redshift};
                    s_tuser  <= rq.command;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, stall at random
    always @(posedge aclk) begin
        distance_rsp_t ex;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result value=%h sat=%b", $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    ex = expected_rsps.pop_front();
                    if (m_tdata !== ex.value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, ex.value, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== ex.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, ex.sat, m_tuser);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0) recv_stall <= pick_gap();
            end
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            cdi_pkg::REG_HUBBLE: h0_reg    = val[15:0];
            cdi_pkg::REG_OMEGA:  omega_reg = val;
            cdi_pkg::REG_STEPS:  steps_reg = val[12:0];
            default: ;
        endcase
    endtask

    task automatic queue_req(input logic [1:0] cmd, input logic [25:0] z);
        distance_req_t rq;
        rq.command  = cmd;
        rq.redshift = z;
        pending_reqs.push_back(rq);
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [25:0] z;
        int          r;
        bit          lookback_used;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 32'd0;
        s_tuser     = 2'd0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = 2'd0;
        cfg_wdata   = 17'd0;
        error_count = 0;
        no_idle     = 1'b0;
        h0_reg      = cdi_pkg::HUBBLE_RST;
        omega_reg   = cdi_pkg::OMEGA_RST;
        steps_reg   = cdi_pkg::STEPS_RST;
        lookback_used = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: zero redshift on every command, one full lookback
        for (int c = 0; c < 4; c++) queue_req(c[1:0], 26'd0);
        queue_req(cdi_pkg::CMD_LOOKBACK, 26'd65536);
        wait_idle();

        // Zero H0 saturates; zero step count acts as one
        write_reg(cdi_pkg::REG_HUBBLE, 17'd0);
        write_reg(cdi_pkg::REG_OMEGA, 17'd0);
        write_reg(cdi_pkg::REG_STEPS, 17'd0);
        queue_req(cdi_pkg::CMD_COMOVING, 26'd5);
        queue_req(cdi_pkg::CMD_LOOKBACK, 26'd0);
        wait_idle();
        write_reg(cdi_pkg::REG_HUBBLE, 17'd17254);
        for (int c = 0; c < 3; c++) begin
            queue_req(c[1:0], 26'h3FF_FFFF);
            queue_req(c[1:0], 26'd1);
        end
        wait_idle();

        // Lowest H0, Omega_M of one, step count above the maximum
        write_reg(cdi_pkg::REG_HUBBLE, 17'd256);
        write_reg(cdi_pkg::REG_OMEGA, 17'd65536);
        write_reg(cdi_pkg::REG_STEPS, 17'd4096);
        queue_req(cdi_pkg::CMD_ANGULAR, 26'd0);
        wait_idle();
        write_reg(cdi_pkg::REG_STEPS, 17'd8191);
        queue_req(cdi_pkg::CMD_LUMINOSITY, 26'h3FF_FFFF);
        wait_idle();

        // Highest H0, single interval, alternating bit patterns
        write_reg(cdi_pkg::REG_HUBBLE, 17'd65535);
        write_reg(cdi_pkg::REG_OMEGA, 17'd1);
        write_reg(cdi_pkg::REG_STEPS, 17'd1);
        for (int c = 0; c < 3; c++) begin
            queue_req(c[1:0], 26'h2AA_AAAA);
            queue_req(c[1:0], 26'h155_5555);
        end
        wait_idle();

        // Random phases with small step counts; nonzero lookback only once
        for (int ph = 0; ph < 4; ph++) begin
            no_idle = (ph == 2);
            write_reg(cdi_pkg::REG_HUBBLE, ($urandom_range(0, 9) == 0) ? 17'd0
                                   : 17'($urandom_range(256, 65535)));
            write_reg(cdi_pkg::REG_OMEGA, 17'($urandom_range(0, 65536)));
            write_reg(cdi_pkg::REG_STEPS, 17'($urandom_range(1, 4)));
            for (int k = 0; k < 25; k++) begin
                cmd = 2'($urandom_range(0, 3));
                r   = $urandom_range(0, 9);
                if (r < 4) z = 26'($urandom);
                else if (r < 8) z = 26'($urandom_range(1, 1 << 20));
                else if (r < 9) z = 26'd0;
                else z = 26'h3FF_FFFF;
                if (cmd == cdi_pkg::CMD_LOOKBACK && z != 0) begin
                    if (lookback_used) z = 26'd0;
                    lookback_used = 1'b1;
                end
                queue_req(cmd, z);
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #(64'd40_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

[cosmic_distance_integrator_top.f]
sv/cdi_pkg.sv
sv/cdi_arith.sv
sv/cosmic_distance_integrator_top.sv
bench/tb_top.sv
